/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every rising clock edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

/* sv/aeps_pkg.sv */
// ----------------------------------------------------------------------------
// aeps_pkg
// Types and constants of the active/expired priority scheduler.
// ----------------------------------------------------------------------------
package aeps_pkg;

  localparam int LEVELS      = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int PID_BITS    = 8;

  localparam int LEVEL_BITS = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int QPTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int EFF_BITS   = $clog2(LEVELS + 1);
  localparam int ADDR_BITS  = 1 + LEVEL_BITS + QPTR_BITS;

  localparam int LC_BITS    = 4;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PREEMPT_EN  = 2'd1;
  localparam logic [LC_BITS-1:0]      LC_RESET        = 4'd4;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_GET     = 2'd1,
    ACT_PREEMPT = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_FULL = 2'd1,
    ERR_PRIO = 2'd2
  } err_e;

  // queue outcome of one word
  typedef struct packed {
    logic       found;
    logic       switched;
    logic [2:0] new_prio;
    err_e       err;
  } qres_t;

  // entry RAM access of one word
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [PID_BITS-1:0]  wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } mem_req_t;

endpackage

/* sv/aeps_entry_ram.sv */
// ----------------------------------------------------------------------------
// aeps_entry_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module aeps_entry_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/aeps_queue_ctrl.sv */
// ----------------------------------------------------------------------------
// aeps_queue_ctrl
// FIFO heads, fill counts and bank select; decodes add and get-next words.
// ----------------------------------------------------------------------------
module aeps_queue_ctrl import aeps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_v_i,
  input  action_e             action_i,
  input  logic [PID_BITS-1:0] pid_i,
  input  logic [3:0]          dyn_prio_i,
  input  logic [3:0]          stat_prio_i,
  input  logic [EFF_BITS-1:0] eff_levels_i,
  output qres_t               res_o,
  output mem_req_t            mem_o
);

  logic [CNT_BITS-1:0]  cnt_q  [2][LEVELS];
  logic [QPTR_BITS-1:0] head_q [2][LEVELS];
  logic                 act_q;

  logic                  neg;
  logic signed [4:0]     np;
  logic                  bad;
  logic                  bank_add;
  logic [LEVEL_BITS-1:0] lv_add;
  logic                  full;
  logic [CNT_BITS-1:0]   slot_sum;
  logic [QPTR_BITS-1:0]  slot;
  logic                  add_ok;

  logic                  any_act;
  logic                  swap;
  logic                  bank_get;
  logic                  hit;
  logic [LEVEL_BITS-1:0] lv_get;
  logic                  do_add;
  logic                  do_get;

  assign do_add = item_v_i && (action_i == ACT_ADD);
  assign do_get = item_v_i && (action_i == ACT_GET);

  // add: an exhausted process goes to the expired bank at static prio minus one
  always_comb begin
    neg      = dyn_prio_i[3];
    np       = neg ? ($signed({1'b0, stat_prio_i}) - 5'sd1)
                   : $signed({dyn_prio_i[3], dyn_prio_i});
    bad      = np[4] || ({1'b0, np[3:0]} >= 5'(eff_levels_i));
    bank_add = act_q ^ neg;
    lv_add   = np[LEVEL_BITS-1:0];
    full     = cnt_q[bank_add][lv_add] >= CNT_BITS'(QUEUE_DEPTH);
    slot_sum = CNT_BITS'(head_q[bank_add][lv_add]) + cnt_q[bank_add][lv_add];
    if (slot_sum >= CNT_BITS'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - CNT_BITS'(QUEUE_DEPTH);
    end
    slot   = slot_sum[QPTR_BITS-1:0];
    add_ok = !bad && !full;
  end

  // get-next: swap once on an empty active bank, then take the highest level
  always_comb begin
    any_act = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      if (l < int'(eff_levels_i) && cnt_q[act_q][l] != '0) begin
        any_act = 1'b1;
      end
    end
    swap     = !any_act;
    bank_get = act_q ^ swap;
    hit      = 1'b0;
    lv_get   = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (l < int'(eff_levels_i) && cnt_q[bank_get][l] != '0) begin
        hit    = 1'b1;
        lv_get = LEVEL_BITS'(l);
      end
    end
  end

  always_comb begin
    res_o = '{found: 1'b0, switched: 1'b0, new_prio: 3'd0, err: ERR_OK};
    if (action_i == ACT_ADD) begin
      if (bad) begin
        res_o.err = ERR_PRIO;
      end else begin
        res_o.new_prio = np[2:0];
        if (full) begin
          res_o.err = ERR_FULL;
        end
      end
    end else if (action_i == ACT_GET) begin
      res_o.found    = hit;
      res_o.switched = swap;
    end
  end

  always_comb begin
    mem_o.we    = do_add && add_ok;
    mem_o.waddr = {bank_add, lv_add, slot};
    mem_o.wdata = pid_i;
    mem_o.re    = do_get && hit;
    mem_o.raddr = {bank_get, lv_get, head_q[bank_get][lv_get]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        for (int l = 0; l < LEVELS; l++) begin
          cnt_q[b][l]  <= '0;
          head_q[b][l] <= '0;
        end
      end
    end else begin
      if (do_add && add_ok) begin
        cnt_q[bank_add][lv_add] <= cnt_q[bank_add][lv_add] + CNT_BITS'(1);
      end
      if (do_get) begin
        if (swap) begin
          act_q <= ~act_q;
        end
        if (hit) begin
          cnt_q[bank_get][lv_get] <= cnt_q[bank_get][lv_get] - CNT_BITS'(1);
          if (head_q[bank_get][lv_get] == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
            head_q[bank_get][lv_get] <= '0;
          end else begin
            head_q[bank_get][lv_get] <= head_q[bank_get][lv_get] + QPTR_BITS'(1);
          end
        end
      end
    end
  end

endmodule

/* sv/active_expired_priority_scheduler.sv */
// ----------------------------------------------------------------------------
// active_expired_priority_scheduler
// Ready-queue engine with active and expired banks of per-level FIFOs.
// ----------------------------------------------------------------------------
// A word is taken into the input register; its result then strobes on done_o.
// Throughput: one word per cycle while busy is low; queue state updates in
//   the decode cycle, so back-to-back words see each other's effect.
// Reset: heads, counts and bank select clear at once; busy stays high for
//   the first cycle after reset is released. The entry RAM is not cleared.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
`include "assert_macros.svh"

module active_expired_priority_scheduler import aeps_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              action_i,
  input  logic [7:0]              pid_i,
  input  logic signed [3:0]       dynamic_prio_i,
  input  logic [3:0]              static_prio_i,
  input  logic                    running_valid_i,
  input  logic [2:0]              running_prio_i,
  input  logic                    pending_valid_i,
  input  logic [23:0]             pending_time_i,
  input  logic [23:0]             current_time_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [LC_BITS-1:0]      cfg_data_i,
  output logic                    done_o,
  output logic [7:0]              out_pid_o,
  output logic                    found_o,
  output logic [2:0]              new_dynamic_prio_o,
  output logic                    banks_switched_o,
  output logic                    preempt_o,
  output logic signed [24:0]      time_to_pending_o,
  output logic [1:0]              error_code_o
);

  logic                busy_q;
  logic [LC_BITS-1:0]  lc_q;
  logic                pe_q;
  logic [EFF_BITS-1:0] eff_levels;

  // input register
  logic                in_v_q;
  action_e             act_q;
  logic [PID_BITS-1:0] pid_q;
  logic [3:0]          dp_q;
  logic [3:0]          sp_q;
  logic                run_v_q;
  logic [2:0]          run_p_q;
  logic                pend_v_q;
  logic [23:0]         pend_t_q;
  logic [23:0]         cur_t_q;

  // result register
  logic                done_q;
  qres_t               res_q;
  logic                pre_q;
  logic [24:0]         ttp_q;

  qres_t               qres;
  mem_req_t            mreq;
  logic [PID_BITS-1:0] rd_pid;
  logic                accept;
  logic                chk_pre;
  logic                pre_d;
  logic [24:0]         ttp_d;

  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      lc_q   <= LC_RESET;
      pe_q   <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_LEVEL_COUNT: lc_q <= cfg_data_i;
          CFG_PREEMPT_EN:  pe_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // clamp level count into one .. LEVELS
  always_comb begin
    if (lc_q == '0) begin
      eff_levels = EFF_BITS'(1);
    end else if (32'(lc_q) > LEVELS) begin
      eff_levels = EFF_BITS'(LEVELS);
    end else begin
      eff_levels = EFF_BITS'(lc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      // drop the unused action code: it produces no word
      in_v_q <= accept && (action_e'(action_i) != ACT_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= action_e'(action_i);
      pid_q    <= PID_BITS'(pid_i);
      dp_q     <= dynamic_prio_i;
      sp_q     <= static_prio_i;
      run_v_q  <= running_valid_i;
      run_p_q  <= running_prio_i;
      pend_v_q <= pending_valid_i;
      pend_t_q <= pending_time_i;
      cur_t_q  <= current_time_i;
    end
  end

  aeps_queue_ctrl u_qctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_v_i     (in_v_q),
    .action_i     (act_q),
    .pid_i        (pid_q),
    .dyn_prio_i   (dp_q),
    .stat_prio_i  (sp_q),
    .eff_levels_i (eff_levels),
    .res_o        (qres),
    .mem_o        (mreq)
  );

  aeps_entry_ram #(
    .ADDR_W (ADDR_BITS),
    .DATA_W (PID_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mreq.we),
    .waddr_i (mreq.waddr),
    .wdata_i (mreq.wdata),
    .re_i    (mreq.re),
    .raddr_i (mreq.raddr),
    .rdata_o (rd_pid)
  );

  // preemption test
  always_comb begin
    chk_pre = (act_q == ACT_PREEMPT) && pe_q && run_v_q && pend_v_q;
    pre_d   = 1'b0;
    ttp_d   = '0;
    if (chk_pre) begin
      pre_d = ($signed({dp_q[3], dp_q}) > $signed({2'b00, run_p_q}))
              && (pend_t_q > cur_t_q);
      ttp_d = {1'b0, pend_t_q} - {1'b0, cur_t_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_v_q) begin
      res_q <= qres;
      pre_q <= pre_d;
      ttp_q <= ttp_d;
    end
  end

  assign done_o             = done_q;
  assign found_o            = res_q.found;
  assign out_pid_o          = res_q.found ? 8'(rd_pid) : 8'd0;
  assign new_dynamic_prio_o = res_q.new_prio;
  assign banks_switched_o   = res_q.switched;
  assign error_code_o       = res_q.err;
  assign preempt_o          = pre_q;
  assign time_to_pending_o  = $signed(ttp_q);

  `ASSERT_AT(a_done_follows, clk_i, rst_ni, (start && !busy && action_i != ACT_NONE) |=> ##1 done_o)
  `ASSERT_AT(a_done_cause, clk_i, rst_ni, done_o |-> $past(start && !busy && action_i != ACT_NONE, 2))
  `ASSERT_NEVER(a_found_no_err, clk_i, rst_ni, done_o && found_o && error_code_o != ERR_OK)
  `ASSERT_AT(a_preempt_future, clk_i, rst_ni, (done_o && preempt_o) |-> (!time_to_pending_o[24] && time_to_pending_o != 0))

endmodule
